FILE: src/teq_pkg.sv
// Shared types and constants for the timed event queue.
package teq_pkg;

   localparam int TEQ_DEPTH      = 16;
   localparam int TEQ_TAG_BITS   = 16;
   localparam int TIME_BITS      = 63;
   localparam int FIELD_TAG_BITS = 16;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_POLL   = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_MARK,
      CELL_COMPACT,
      CELL_CLEAR
   } cell_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type op;
      logic        phase;
   } cell_ctl_type;

endpackage

FILE: src/teq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module teq_cell #(
   parameter int TAG_BITS = teq_pkg::TEQ_TAG_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  teq_pkg::cell_ctl_type        ctl,
   input  logic                         pair_low,
   input  logic [teq_pkg::TIME_BITS-1:0] new_time,
   input  logic [TAG_BITS-1:0]          new_tag,
   input  logic                         left_valid,
   input  logic                         left_ge,
   input  logic [teq_pkg::TIME_BITS-1:0] left_time,
   input  logic [TAG_BITS-1:0]          left_tag,
   input  logic                         right_valid,
   input  logic [teq_pkg::TIME_BITS-1:0] right_time,
   input  logic [TAG_BITS-1:0]          right_tag,
   output logic                         valid,
   output logic                         ge,
   output logic [teq_pkg::TIME_BITS-1:0] time_val,
   output logic [TAG_BITS-1:0]          tag
);

   logic                          valid_ff, valid_in;
   logic [teq_pkg::TIME_BITS-1:0] time_ff, time_in;
   logic [TAG_BITS-1:0]           tag_ff, tag_in;

   // empty or not earlier than the new entry: the new entry lands at or before here
   assign ge       = !valid_ff || (time_ff >= new_time);
   assign valid    = valid_ff;
   assign time_val = time_ff;
   assign tag      = tag_ff;

   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      tag_in   = tag_ff;
      case (ctl.op)
         teq_pkg::CELL_INSERT: begin
            if (ge && left_ge) begin
               valid_in = left_valid;
               time_in  = left_time;
               tag_in   = left_tag;
            end else if (ge) begin
               valid_in = 1'b1;
               time_in  = new_time;
               tag_in   = new_tag;
            end
         end
         teq_pkg::CELL_POP: begin
            valid_in = right_valid;
            time_in  = right_time;
            tag_in   = right_tag;
         end
         teq_pkg::CELL_MARK: begin
            valid_in = valid_ff && (tag_ff != new_tag);
         end
         teq_pkg::CELL_COMPACT: begin
            // odd-even pass: a live entry steps left into an empty partner
            if (pair_low) begin
               if (!valid_ff && right_valid) begin
                  valid_in = 1'b1;
                  time_in  = right_time;
                  tag_in   = right_tag;
               end
            end else if (valid_ff && !left_valid) begin
               valid_in = 1'b0;
            end
         end
         teq_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      tag_ff  <= tag_in;
   end

endmodule

FILE: src/timed_event_queue_top.sv
// Top level of the timed event queue: a sorted chain of entry cells and its sequencer.
// Insert, poll and clear: cells update on the request transfer, and the response is
// registered in the finish state that follows. Remove: matching tags are dropped on the
// transfer, then odd-even passes compact the chain. Requests stall outside the idle state.
// Synchronous active-high reset empties the queue at once (valid bits only);
// entry payload is not reset.
module timed_event_queue_top #(
   parameter int QUEUE_DEPTH = teq_pkg::TEQ_DEPTH,
   parameter int TAG_BITS    = teq_pkg::TEQ_TAG_BITS,
   localparam int OCC_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_mode,
   input  logic [teq_pkg::TIME_BITS-1:0]      req_event_time,
   input  logic [teq_pkg::FIELD_TAG_BITS-1:0] req_task_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_fired,
   output logic [teq_pkg::FIELD_TAG_BITS-1:0] rsp_fired_tag,
   output logic [teq_pkg::TIME_BITS-1:0]      rsp_fired_time,
   output logic [teq_pkg::TIME_BITS-1:0]      rsp_wait_left,
   output logic [OCC_BITS-1:0]                rsp_occupancy,
   output logic                               rsp_dropped
);

   localparam int PH_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPACT,
      ST_FINISH
   } state_type;

   state_type            state_ff;
   logic [PH_BITS-1:0]   phase_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_fired_ff;
   logic [teq_pkg::FIELD_TAG_BITS-1:0] rsp_fired_tag_ff;
   logic [teq_pkg::TIME_BITS-1:0]      rsp_fired_time_ff;
   logic [teq_pkg::TIME_BITS-1:0]      rsp_wait_left_ff;
   logic [OCC_BITS-1:0]  rsp_occupancy_ff;
   logic                 rsp_dropped_ff;

   // chain taps; valid_vec has a constant empty slot past the last cell
   logic [QUEUE_DEPTH:0]          valid_vec;
   logic [QUEUE_DEPTH-1:0]        ge_vec;
   logic [teq_pkg::TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]           cell_tag  [QUEUE_DEPTH];

   teq_pkg::cell_ctl_type ctl;
   logic                  accept;
   logic                  full;
   logic                  head_due;
   logic [TAG_BITS-1:0]   tag_in;
   logic [OCC_BITS-1:0]   occ_count;
   teq_pkg::mode_type     mode;

   assign mode      = teq_pkg::mode_type'(req_mode);
   assign tag_in    = TAG_BITS'(req_task_tag);
   assign full      = valid_vec[QUEUE_DEPTH-1];
   // head at or before the current time is due
   assign head_due  = valid_vec[0] && (cell_time[0] <= req_event_time);

   // one request in flight; the response register frees up on the same edge it is taken
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // command broadcast to all cells
   always_comb begin
      ctl.op    = teq_pkg::CELL_HOLD;
      ctl.phase = phase_ff[0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode)
                  teq_pkg::MODE_INSERT: ctl.op = full ? teq_pkg::CELL_HOLD
                                                      : teq_pkg::CELL_INSERT;
                  teq_pkg::MODE_POLL:   ctl.op = head_due ? teq_pkg::CELL_POP
                                                          : teq_pkg::CELL_HOLD;
                  teq_pkg::MODE_REMOVE: ctl.op = teq_pkg::CELL_MARK;
                  teq_pkg::MODE_CLEAR:  ctl.op = teq_pkg::CELL_CLEAR;
                  default:              ctl.op = teq_pkg::CELL_HOLD;
               endcase
            end
         end
         ST_COMPACT: ctl.op = teq_pkg::CELL_COMPACT;
         default:    ctl.op = teq_pkg::CELL_HOLD;
      endcase
   end

   assign valid_vec[QUEUE_DEPTH] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam logic PARITY = 1'(i % 2);
      logic                          l_valid;
      logic                          l_ge;
      logic [teq_pkg::TIME_BITS-1:0] l_time;
      logic [TAG_BITS-1:0]           l_tag;
      logic [teq_pkg::TIME_BITS-1:0] r_time;
      logic [TAG_BITS-1:0]           r_tag;

      if (i == 0) begin : g_left_edge
         // head never moves left in a compaction pass, never takes a left entry
         assign l_valid = 1'b1;
         assign l_ge    = 1'b0;
         assign l_time  = '0;
         assign l_tag   = '0;
      end else begin : g_left
         assign l_valid = valid_vec[i-1];
         assign l_ge    = ge_vec[i-1];
         assign l_time  = cell_time[i-1];
         assign l_tag   = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_right_edge
         assign r_time = '0;
         assign r_tag  = '0;
      end else begin : g_right
         assign r_time = cell_time[i+1];
         assign r_tag  = cell_tag[i+1];
      end

      teq_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .pair_low    (ctl.phase == PARITY),
         .new_time    (req_event_time),
         .new_tag     (tag_in),
         .left_valid  (l_valid),
         .left_ge     (l_ge),
         .left_time   (l_time),
         .left_tag    (l_tag),
         .right_valid (valid_vec[i+1]),
         .right_time  (r_time),
         .right_tag   (r_tag),
         .valid       (valid_vec[i]),
         .ge          (ge_vec[i]),
         .time_val    (cell_time[i]),
         .tag         (cell_tag[i])
      );
   end

   // valid bits are packed at the low end: the last live slot gives the count
   always_comb begin
      occ_count = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (valid_vec[i] && !valid_vec[i+1]) begin
            occ_count = occ_count | OCC_BITS'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // fire/wait/drop fields are known at transfer; count comes later
                  rsp_fired_ff      <= (mode == teq_pkg::MODE_POLL) && head_due;
                  rsp_fired_tag_ff  <= ((mode == teq_pkg::MODE_POLL) && head_due) ?
                                       teq_pkg::FIELD_TAG_BITS'(cell_tag[0]) : '0;
                  rsp_fired_time_ff <= ((mode == teq_pkg::MODE_POLL) && head_due) ?
                                       cell_time[0] : '0;
                  rsp_wait_left_ff  <= ((mode == teq_pkg::MODE_POLL) && valid_vec[0]
                                        && !head_due) ?
                                       (cell_time[0] - req_event_time) : '0;
                  rsp_dropped_ff    <= (mode == teq_pkg::MODE_INSERT) && full;
                  phase_ff          <= '0;
                  state_ff          <= (mode == teq_pkg::MODE_REMOVE) ? ST_COMPACT
                                                                      : ST_FINISH;
               end
            end
            ST_COMPACT: begin
               if (phase_ff == PH_BITS'(QUEUE_DEPTH - 1)) begin
                  state_ff <= ST_FINISH;
               end
               phase_ff <= phase_ff + 1'b1;
            end
            ST_FINISH: begin
               rsp_occupancy_ff <= occ_count;
               rsp_valid_ff     <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_fired_tag  = rsp_fired_tag_ff;
   assign rsp_fired_time = rsp_fired_time_ff;
   assign rsp_wait_left  = rsp_wait_left_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;
   assign rsp_dropped    = rsp_dropped_ff;

endmodule

FILE: src/teq_checker.sv
// Port-level checks for the timed event queue, bound to the top level.
module teq_checker #(
   parameter int QUEUE_DEPTH = teq_pkg::TEQ_DEPTH,
   localparam int OCC_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_fired,
   input logic [teq_pkg::FIELD_TAG_BITS-1:0] rsp_fired_tag,
   input logic [teq_pkg::TIME_BITS-1:0]      rsp_fired_time,
   input logic [teq_pkg::TIME_BITS-1:0]      rsp_wait_left,
   input logic [OCC_BITS-1:0]                rsp_occupancy,
   input logic                               rsp_dropped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fired_tag)
         && $stable(rsp_fired_time) && $stable(rsp_wait_left) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_fired_tag == '0 && rsp_fired_time == '0)
      else $error("fired fields set without a fire");

   a_fire_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_wait_left == '0 && !rsp_dropped
         && rsp_fired_time <= rsp_fired_time)
      else $error("fire reported with wait or drop");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_occupancy == OCC_BITS'(QUEUE_DEPTH))
      else $error("drop reported while queue not full");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= OCC_BITS'(QUEUE_DEPTH))
      else $error("occupancy beyond depth");

endmodule

bind timed_event_queue_top teq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_teq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_fired      (rsp_fired),
   .rsp_fired_tag  (rsp_fired_tag),
   .rsp_fired_time (rsp_fired_time),
   .rsp_wait_left  (rsp_wait_left),
   .rsp_occupancy  (rsp_occupancy),
   .rsp_dropped    (rsp_dropped)
);
